@@ hdl/isl_pkg.sv @@
package isl_pkg;

  localparam int POS_W = 11;

  typedef enum logic [3:0] {
    OP_APPEND   = 4'd0,
    OP_INSERT   = 4'd1,
    OP_REMOVE   = 4'd2,
    OP_SWAP     = 4'd3,
    OP_FRONT    = 4'd4,
    OP_POP      = 4'd5,
    OP_READ_AT  = 4'd6,
    OP_FIRST    = 4'd7,
    OP_NEXT     = 4'd8,
    OP_LAST     = 4'd9,
    OP_TRUNCATE = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_HOLD
  } state_t;

  typedef enum logic [1:0] {
    C_HOLD,
    C_INSERT,
    C_REMOVE,
    C_SWAP
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   lo;
    logic [POS_W-1:0]   hi;
  } cell_cmd_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        read_value;
    logic signed [7:0]  cursor_position;
    logic [6:0]         list_length;
  } res_t;

endpackage

@@ hdl/indexed_shift_list.sv @@
// Ordered list of up to DEPTH words held in a row of cells, one word per
// cell; insert, remove, pop and move to front shift the affected span in
// one update. Append, insert, remove, pop, read first, truncate and every
// rejected operation finish when taken, and a new item may follow unless
// the output is stalled. Read at, read next, read last, move to front and
// swap wait, taking no new item, for the registered OR tree that brings a
// word from an arbitrary cell back to the control logic; swap fetches two
// words. A result register sits on the output, so a new item is taken
// while the previous result waits. Entries hold no reset value and need
// no clearing pass: only written positions are ever inside the list.
module indexed_shift_list #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [3:0]        in_operation,
  input  logic [6:0]        in_index,
  input  logic [5:0]        in_second_index,
  input  logic [31:0]       in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [31:0]       out_read_value,
  output logic signed [7:0] out_cursor_position,
  output logic [6:0]        out_list_length
);
  import isl_pkg::*;

  localparam int LW    = $clog2(DEPTH + 1);
  localparam int CW    = LW + 1;
  localparam int LG    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(LG + 1);
  localparam logic signed [CW-1:0] DEPTH_S = CW'(DEPTH);

  state_t                state_r, state_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  logic signed [CW-1:0]  cur_r, cur_nxt;
  op_t                   op_r, op_nxt;
  logic [POS_W-1:0]      lo_r, lo_nxt;
  logic [POS_W-1:0]      hi_r, hi_nxt;
  logic                  second_r, second_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] tmp_r, tmp_nxt;
  res_t                  res_r, res_nxt;
  res_t                  out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  cell_cmd_t             cmd;
  logic [POS_W-1:0]      rd_pos;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [DATA_WIDTH-1:0] alt_data;
  logic [DATA_WIDTH-1:0] root;
  logic [DEPTH-1:0][DATA_WIDTH-1:0] cell_d;
  logic [DEPTH-1:0][DATA_WIDTH-1:0] sel_d;
  logic [DEPTH-1:0][DATA_WIDTH-1:0] left_d;
  logic [DEPTH-1:0][DATA_WIDTH-1:0] right_d;

  logic                  acc;
  logic                  out_free;
  logic                  fin;
  status_t               fin_st;
  logic [DATA_WIDTH-1:0] fin_rd;
  res_t                  fin_res;
  logic                  load_out;
  op_t                   op_in;
  logic [DATA_WIDTH-1:0] val_dw;
  logic [POS_W-1:0]      idx_e, idx2_e, len_e, last_pos, adv_pos;
  logic signed [CW-1:0]  cur_adv;
  logic signed [CW-1:0]  len_s;
  logic                  full;

  // cell row
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_d[k] = '0;
    end else begin : g_left
      assign left_d[k] = cell_d[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_d[k] = '0;
    end else begin : g_right
      assign right_d[k] = cell_d[k+1];
    end
    isl_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk      (clk),
      .cell_pos (POS_W'(k)),
      .cmd      (cmd),
      .rd_pos   (rd_pos),
      .wr_data  (wr_data),
      .alt_data (alt_data),
      .left_d   (left_d[k]),
      .right_d  (right_d[k]),
      .d        (cell_d[k]),
      .sel_d    (sel_d[k])
    );
  end

  isl_tree #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_tree (
    .clk    (clk),
    .leaf_d (sel_d),
    .root_d (root)
  );

  assign acc      = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign op_in    = op_t'(in_operation);
  assign val_dw   = DATA_WIDTH'(in_value);
  assign idx_e    = POS_W'(in_index);
  assign idx2_e   = POS_W'(in_second_index);
  assign len_e    = POS_W'(len_r);
  assign last_pos = len_e - POS_W'(1);
  assign full     = (len_r == LW'(DEPTH));
  assign len_s    = $signed({1'b0, len_r});
  assign cur_adv  = (cur_r < DEPTH_S) ? cur_r + CW'(1) : cur_r;
  assign adv_pos  = POS_W'($unsigned(cur_adv));

  always_comb begin
    state_nxt  = state_r;
    len_nxt    = len_r;
    cur_nxt    = cur_r;
    op_nxt     = op_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    second_nxt = second_r;
    cnt_nxt    = cnt_r;
    tmp_nxt    = tmp_r;
    cmd        = '{op: C_HOLD, lo: '0, hi: '0};
    wr_data    = val_dw;
    alt_data   = tmp_r;
    rd_pos     = idx_e;
    fin        = 1'b0;
    fin_st     = ST_OK;
    fin_rd     = '0;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          fin        = 1'b1;
          op_nxt     = op_in;
          lo_nxt     = idx_e;
          hi_nxt     = idx2_e;
          second_nxt = 1'b0;
          cnt_nxt    = CNT_W'(LG);
          case (op_in)
            OP_APPEND: begin
              if (full) begin
                fin_st = ST_FULL;
              end else begin
                cmd     = '{op: C_INSERT, lo: len_e, hi: len_e};
                len_nxt = len_r + LW'(1);
              end
            end
            OP_INSERT: begin
              if (idx_e > len_e) begin
                fin_st = ST_BAD;
              end else if (full) begin
                fin_st = ST_FULL;
              end else begin
                cmd     = '{op: C_INSERT, lo: idx_e, hi: len_e};
                len_nxt = len_r + LW'(1);
              end
            end
            OP_REMOVE: begin
              if (idx_e >= len_e) begin
                fin_st = ST_BAD;
              end else begin
                cmd     = '{op: C_REMOVE, lo: idx_e, hi: last_pos};
                len_nxt = len_r - LW'(1);
              end
            end
            OP_SWAP: begin
              if (idx_e >= len_e || idx2_e >= len_e) begin
                fin_st = ST_BAD;
              end else begin
                fin       = 1'b0;
                state_nxt = S_FETCH;
              end
            end
            OP_FRONT: begin
              if (idx_e == '0 || idx_e >= len_e) begin
                fin_st = ST_BAD;
              end else begin
                fin       = 1'b0;
                state_nxt = S_FETCH;
              end
            end
            OP_POP: begin
              if (len_r == '0) begin
                fin_st = ST_BAD;
              end else begin
                fin_rd  = cell_d[0];
                cmd     = '{op: C_REMOVE, lo: '0, hi: last_pos};
                len_nxt = len_r - LW'(1);
              end
            end
            OP_READ_AT: begin
              if (idx_e >= len_e) begin
                fin_st = ST_BAD;
              end else begin
                cur_nxt   = CW'(in_index);
                fin       = 1'b0;
                state_nxt = S_FETCH;
              end
            end
            OP_FIRST: begin
              if (len_r == '0) begin
                fin_st = ST_BAD;
              end else begin
                cur_nxt = '0;
                fin_rd  = cell_d[0];
              end
            end
            OP_NEXT: begin
              cur_nxt = cur_adv;
              rd_pos  = adv_pos;
              if (cur_adv < 0 || cur_adv >= len_s) begin
                fin_st = ST_BAD;
              end else begin
                fin       = 1'b0;
                state_nxt = S_FETCH;
              end
            end
            OP_LAST: begin
              rd_pos = last_pos;
              if (len_r == '0) begin
                fin_st = ST_BAD;
              end else begin
                cur_nxt   = $signed({1'b0, len_r - LW'(1)});
                fin       = 1'b0;
                state_nxt = S_FETCH;
              end
            end
            OP_TRUNCATE: begin
              if (idx_e < len_e) begin
                len_nxt = LW'(in_index);
              end
            end
            default: begin
              fin_st = ST_BAD;
            end
          endcase
          if (fin && !out_free) begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_FETCH: begin
        rd_pos = hi_r;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else if (op_r == OP_SWAP && !second_r) begin
          tmp_nxt    = root;
          second_nxt = 1'b1;
        end else begin
          fin = 1'b1;
          case (op_r)
            OP_SWAP: begin
              cmd      = '{op: C_SWAP, lo: lo_r, hi: hi_r};
              wr_data  = root;
              alt_data = tmp_r;
            end
            OP_FRONT: begin
              cmd     = '{op: C_INSERT, lo: '0, hi: lo_r};
              wr_data = root;
            end
            default: begin
              fin_rd = root;
            end
          endcase
          state_nxt = out_free ? S_IDLE : S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result staging
  always_comb begin
    fin_res.status          = fin_st;
    fin_res.read_value      = 32'(fin_rd);
    fin_res.cursor_position = 8'(cur_nxt);
    fin_res.list_length     = 7'(len_nxt);
    res_nxt                 = fin ? fin_res : res_r;
    load_out                = out_free && (fin || state_r == S_HOLD);
    out_nxt                 = out_r;
    out_valid_nxt           = out_valid_r && out_stall;
    if (load_out) begin
      out_nxt       = (state_r == S_HOLD) ? res_r : fin_res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      cur_r       <= '1;
      second_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      second_r    <= second_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    tmp_r <= tmp_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_read_value      = out_r.read_value;
  assign out_cursor_position = out_r.cursor_position;
  assign out_list_length     = out_r.list_length;

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= DEPTH)
    else $error("list length above depth");

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r >= -1 && cur_r <= DEPTH)
    else $error("cursor out of range");

  a_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HOLD |-> out_valid_r)
    else $error("held result with empty output register");

  a_fetch_stable: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |=> $stable(len_r) && $stable(cur_r))
    else $error("length or cursor changed during fetch");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && !out_free) |=> state_r == S_HOLD)
    else $error("finished item not held while output busy");

endmodule

@@ hdl/isl_cell.sv @@
module isl_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic [isl_pkg::POS_W-1:0]   cell_pos,
  input  isl_pkg::cell_cmd_t          cmd,
  input  logic [isl_pkg::POS_W-1:0]   rd_pos,
  input  logic [DATA_WIDTH-1:0]       wr_data,
  input  logic [DATA_WIDTH-1:0]       alt_data,
  input  logic [DATA_WIDTH-1:0]       left_d,
  input  logic [DATA_WIDTH-1:0]       right_d,
  output logic [DATA_WIDTH-1:0]       d,
  output logic [DATA_WIDTH-1:0]       sel_d
);
  import isl_pkg::*;

  logic [DATA_WIDTH-1:0] d_r;
  logic [DATA_WIDTH-1:0] d_nxt;

  always_comb begin
    d_nxt = d_r;
    case (cmd.op)
      C_HOLD: begin
        d_nxt = d_r;
      end
      C_INSERT: begin
        if (cell_pos == cmd.lo) begin
          d_nxt = wr_data;
        end else if (cell_pos > cmd.lo && cell_pos <= cmd.hi) begin
          d_nxt = left_d;
        end
      end
      C_REMOVE: begin
        if (cell_pos >= cmd.lo && cell_pos < cmd.hi) begin
          d_nxt = right_d;
        end
      end
      C_SWAP: begin
        if (cell_pos == cmd.lo) begin
          d_nxt = wr_data;
        end else if (cell_pos == cmd.hi) begin
          d_nxt = alt_data;
        end
      end
      default: begin
        d_nxt = d_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  assign d     = d_r;
  assign sel_d = (cell_pos == rd_pos) ? d_r : '0;

endmodule

@@ hdl/isl_tree.sv @@
module isl_tree #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                             clk,
  input  logic [DEPTH-1:0][DATA_WIDTH-1:0] leaf_d,
  output logic [DATA_WIDTH-1:0]            root_d
);
  import isl_pkg::*;

  localparam int NP    = 1 << $clog2(DEPTH);
  localparam int NODES = 2 * NP - 1;

  logic [DATA_WIDTH-1:0] node_r   [NODES];
  logic [DATA_WIDTH-1:0] node_nxt [NODES];

  for (genvar i = 0; i < NP - 1; i++) begin : g_inner
    assign node_nxt[i] = node_r[2*i+1] | node_r[2*i+2];
  end

  for (genvar j = 0; j < NP; j++) begin : g_leaf
    if (j < DEPTH) begin : g_used
      assign node_nxt[NP-1+j] = leaf_d[j];
    end else begin : g_pad
      assign node_nxt[NP-1+j] = '0;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  assign root_d = node_r[0];

endmodule
